// File: hw/rtl/hcd_pkg.sv
// Package for the hysteresis comparator with debounce delay.
// Holds the register indexes, field widths and the configuration struct.
// Used by hcd_step, hysteresis_comparator_delayed and hcd_checker; depends on nothing.
`default_nettype none

package hcd_pkg;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 16;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_POLARITY = 3'd1;
    localparam logic [IDX_W-1:0] REG_UPPER    = 3'd2;
    localparam logic [IDX_W-1:0] REG_LOWER    = 3'd3;
    localparam logic [IDX_W-1:0] REG_DELAY    = 3'd4;

    // Polarity codes.
    localparam logic POL_RISING  = 1'b0;
    localparam logic POL_FALLING = 1'b1;

    // Saturation value of the delay counter.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration as seen by the step logic.
    typedef struct packed {
        logic                       enable;
        logic                       polarity;
        logic signed [SAMPLE_W-1:0] upper;
        logic signed [SAMPLE_W-1:0] lower;
        logic [CNT_W-1:0]           delay;
    } t_cfg;

endpackage

`default_nettype wire

// File: hw/rtl/hcd_step.sv
// Next-state logic of the comparator: band compare, counter and output flip.
// Purely combinational; uses hcd_pkg for widths and the configuration struct.
`default_nettype none

module hcd_step (
    input  var hcd_pkg::t_cfg                       i_cfg,
    input  wire logic signed [hcd_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_clear,
    input  wire logic                                i_level,
    input  wire logic [hcd_pkg::CNT_W-1:0]           i_count,
    output logic                                     o_level,
    output logic [hcd_pkg::CNT_W-1:0]                o_count
);

    logic                          use_upper;
    logic                          in_band;
    logic [hcd_pkg::CNT_W-1:0]     inc_count;

    // The upper threshold guards the band when the output would move toward
    // the polarity's active side from rest in rising mode, or back in falling.
    assign use_upper = (i_level ^ i_cfg.polarity) == hcd_pkg::POL_RISING;
    assign in_band   = use_upper ? (i_sample <= i_cfg.upper)
                                 : (i_sample >= i_cfg.lower);

    // Saturating increment of the delay counter.
    assign inc_count = (i_count == hcd_pkg::CNT_MAX) ? i_count
                                                     : i_count + {{(hcd_pkg::CNT_W-1){1'b0}}, 1'b1};

    // Clear and disable zero everything; an in-band sample clears the counter;
    // otherwise count and flip once the delay is reached.
    always_comb begin
        if (i_clear || !i_cfg.enable) begin
            o_level = 1'b0;
            o_count = '0;
        end else if (in_band) begin
            o_level = i_level;
            o_count = '0;
        end else begin
            o_count = inc_count;
            o_level = (inc_count >= i_cfg.delay) ? ~i_level : i_level;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hysteresis_comparator_delayed.sv
// Hysteresis comparator with debounce delay counter.
// An accepted input word passes through the input register and then the state register
// (which doubles as the result register); together they form a two-stage pipeline.
// Throughput: one word per cycle while the result channel is not stalled by i_ready.
// Reset (synchronous, active low) clears all configuration, the comparator
// output, the delay counter and both valid flags.
`default_nettype none

module hysteresis_comparator_delayed (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [hcd_pkg::IDX_W-1:0]           i_cfg_index,
    input  wire logic [hcd_pkg::CFG_W-1:0]           i_cfg_data,
    // Sample channel.
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [hcd_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_clear,
    // Result channel.
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_level,
    output logic [hcd_pkg::CNT_W-1:0]                o_wait_count
);

    hcd_pkg::t_cfg                       r_cfg;
    logic                                r_in_valid;
    logic signed [hcd_pkg::SAMPLE_W-1:0] r_sample;
    logic                                r_clear;
    logic                                r_out_valid;
    logic                                r_level;
    logic [hcd_pkg::CNT_W-1:0]           r_count;
    logic                                n_level;
    logic [hcd_pkg::CNT_W-1:0]           n_count;
    logic                                advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hcd_pkg::REG_ENABLE:   r_cfg.enable   <= i_cfg_data[0];
                hcd_pkg::REG_POLARITY: r_cfg.polarity <= i_cfg_data[0];
                hcd_pkg::REG_UPPER:    r_cfg.upper    <= $signed(i_cfg_data);
                hcd_pkg::REG_LOWER:    r_cfg.lower    <= $signed(i_cfg_data);
                hcd_pkg::REG_DELAY:    r_cfg.delay    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The input stage moves on when the result register is free or emptying.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sample <= i_sample;
            r_clear  <= i_clear;
        end
    end

    // Next-state computation.
    hcd_step u_step (
        .i_cfg    (r_cfg),
        .i_sample (r_sample),
        .i_clear  (r_clear),
        .i_level  (r_level),
        .i_count  (r_count),
        .o_level  (n_level),
        .o_count  (n_count)
    );

    // State register; it is updated only when a word moves into the result
    // stage, so it also holds the result until that word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_level     <= 1'b0;
            r_count     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_level     <= n_level;
                r_count     <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_level      = r_level;
    assign o_wait_count = r_count;

endmodule

`default_nettype wire

// File: hw/rtl/hcd_checker.sv
// Port-level checks for the hysteresis comparator, bound to its top level.
// Depends on hcd_pkg for widths and on hysteresis_comparator_delayed.
`default_nettype none

module hcd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_valid,
    input wire logic                                i_ready,
    input wire logic                                o_level,
    input wire logic [hcd_pkg::CNT_W-1:0]           o_wait_count
);

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result word holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_level) && $stable(o_wait_count))
        else $error("stalled result changed");

    // Consecutive results: the counter clears, steps by one, or stays saturated.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) ##1 o_valid |->
            (o_wait_count == '0) ||
            (o_wait_count == $past(o_wait_count) + 16'd1) ||
            (o_wait_count == hcd_pkg::CNT_MAX && $past(o_wait_count) == hcd_pkg::CNT_MAX))
        else $error("delay counter jumped");

    // The output only rises after an out-of-band sample, so the counter is nonzero.
    a_rise_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) ##1 (o_valid && o_level && !$past(o_level)) |->
            o_wait_count != '0)
        else $error("output rose with zero counter");

endmodule

bind hysteresis_comparator_delayed hcd_checker u_hcd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_level      (o_level),
    .o_wait_count (o_wait_count)
);

`default_nettype wire
